[rtl/core/fpfa_pkg.sv]
// Package for the fixed-partition fit allocator.
// Holds request and policy codes and the structs passed between the top level
// and the partition cells. Depends on nothing.
`timescale 1ns / 1ps

package fpfa_pkg;

    localparam int AmountW = 16;
    localparam int PolicyW = 2;
    localparam int SlotW   = 3;
    localparam int SeqW    = 8;
    // Wide enough to index up to 64 partitions.
    localparam int SlotIdxW = 6;

    localparam logic ReqDefine = 1'b0;
    localparam logic ReqAlloc  = 1'b1;

    localparam logic [PolicyW-1:0] PolicyFirst = 2'd0;
    localparam logic [PolicyW-1:0] PolicyBest  = 2'd1;
    localparam logic [PolicyW-1:0] PolicyWorst = 2'd2;

    // Search record that travels one cell per cycle down the chain.
    typedef struct packed {
        logic                active;
        logic [AmountW-1:0]  want;
        logic [PolicyW-1:0]  policy;
        logic                found;
        logic [SlotIdxW-1:0] pick_idx;
        logic [AmountW-1:0]  pick_size;
        logic [SlotIdxW-1:0] cur_idx;
    } t_probe;

    // Per-cell update command from the top level.
    typedef struct packed {
        logic               define;
        logic               take;
        logic [AmountW-1:0] size;
    } t_cell_cmd;

endpackage

[rtl/core/fixed_partition_fit_allocator_top.sv]
// Top level of the fixed-partition fit allocator: command handshake, policy
// register, sequencer and the chain of fpfa_cell partitions. Uses fpfa_pkg.
`timescale 1ns / 1ps

// A define item writes the partition at the accept edge, its result (all zero)
// is strobed in the next cycle, and a new item may be started in that same
// cycle. An allocate item sends a search record down the chain of SLOT_COUNT
// partition cells, one cell per cycle, then the pick is committed; busy is
// high while the record is in the chain, and no new item is taken while busy
// is high. Each result is on the result ports for one cycle only, marked by
// o_result_strobe, and must be captured then; the block never holds a result
// back. The policy register may be written at any time the block is idle;
// o_cfg_ready is always high.
module fixed_partition_fit_allocator_top #(
    parameter int SLOT_COUNT = 8
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic                         i_req_type,
    input  logic [fpfa_pkg::SlotW-1:0]   i_slot_index,
    input  logic [fpfa_pkg::AmountW-1:0] i_amount,
    output logic                         o_result_strobe,
    output logic                         o_granted,
    output logic [fpfa_pkg::SlotW-1:0]   o_chosen_slot,
    output logic [fpfa_pkg::SeqW-1:0]    o_request_number,
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic [fpfa_pkg::PolicyW-1:0] i_cfg_data
);

    typedef enum logic [1:0] {
        StIdle = 2'b01,
        StScan = 2'b10
    } t_state;

    t_state                        r_state;
    t_state                        n_state;
    logic [fpfa_pkg::PolicyW-1:0]  r_policy;
    logic [fpfa_pkg::SeqW-1:0]     r_req_count;
    logic [fpfa_pkg::SeqW-1:0]     n_req_count;
    logic                          r_strobe;
    logic                          n_strobe;
    logic                          r_granted;
    logic                          n_granted;
    logic [fpfa_pkg::SlotW-1:0]    r_chosen;
    logic [fpfa_pkg::SlotW-1:0]    n_chosen;
    logic [fpfa_pkg::SeqW-1:0]     r_seq;
    logic [fpfa_pkg::SeqW-1:0]     n_seq;
    logic                          w_accept;
    logic                          w_commit;
    fpfa_pkg::t_probe              w_head;
    fpfa_pkg::t_probe              w_probe [SLOT_COUNT+1];
    fpfa_pkg::t_cell_cmd           w_cmd   [SLOT_COUNT];
    fpfa_pkg::t_probe              w_last;

    assign o_cfg_ready = 1'b1;
    assign busy        = (r_state == StScan);
    assign w_accept    = start && !busy;
    assign w_last      = w_probe[SLOT_COUNT];
    assign w_commit    = (r_state == StScan) && w_last.active;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_policy <= fpfa_pkg::PolicyFirst;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_policy <= i_cfg_data;
        end
    end

    // The search record enters the first cell in the cycle the item is taken.
    always_comb begin
        w_head           = '0;
        w_head.active    = w_accept && (i_req_type == fpfa_pkg::ReqAlloc);
        w_head.want      = i_amount;
        w_head.policy    = r_policy;
    end

    assign w_probe[0] = w_head;

    for (genvar j = 0; j < SLOT_COUNT; j++) begin : g_cell
        always_comb begin
            w_cmd[j].define = w_accept && (i_req_type == fpfa_pkg::ReqDefine)
                              && (32'(i_slot_index) == j);
            w_cmd[j].take   = w_commit && w_last.found
                              && (w_last.pick_idx == fpfa_pkg::SlotIdxW'(j));
            w_cmd[j].size   = i_amount;
        end

        fpfa_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_cmd   (w_cmd[j]),
            .i_probe (w_probe[j]),
            .o_probe (w_probe[j+1])
        );
    end

    always_comb begin
        n_state     = r_state;
        n_req_count = r_req_count;
        n_strobe    = 1'b0;
        n_granted   = 1'b0;
        n_chosen    = '0;
        n_seq       = '0;
        unique case (r_state)
            StIdle: begin
                if (w_accept) begin
                    if (i_req_type == fpfa_pkg::ReqAlloc) begin
                        n_state = StScan;
                    end else begin
                        n_strobe = 1'b1;
                    end
                end
            end
            StScan: begin
                if (w_commit) begin
                    n_state     = StIdle;
                    n_strobe    = 1'b1;
                    n_granted   = w_last.found;
                    n_chosen    = w_last.found ? w_last.pick_idx[fpfa_pkg::SlotW-1:0] : '0;
                    n_seq       = r_req_count;
                    n_req_count = r_req_count + fpfa_pkg::SeqW'(1);
                end
            end
            default: begin
                n_state = StIdle;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= StIdle;
            r_req_count <= '0;
            r_strobe    <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_req_count <= n_req_count;
            r_strobe    <= n_strobe;
        end
    end

    always_ff @(posedge i_clk) begin
        r_granted <= n_granted;
        r_chosen  <= n_chosen;
        r_seq     <= n_seq;
    end

    assign o_result_strobe  = r_strobe;
    assign o_granted        = r_granted;
    assign o_chosen_slot    = r_chosen;
    assign o_request_number = r_seq;

endmodule

[rtl/core/fpfa_cell.sv]
// One partition cell: holds a partition's size, defined bit and taken bit,
// and refines the search record passing through it. Depends on fpfa_pkg.
`timescale 1ns / 1ps

module fpfa_cell (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  fpfa_pkg::t_cell_cmd i_cmd,
    input  fpfa_pkg::t_probe    i_probe,
    output fpfa_pkg::t_probe    o_probe
);

    logic [fpfa_pkg::AmountW-1:0] r_size;
    logic                         r_defined;
    logic                         r_taken;
    fpfa_pkg::t_probe             r_probe;
    fpfa_pkg::t_probe             n_probe;
    logic                         w_fits;
    logic                         w_pick;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_defined <= 1'b0;
            r_taken   <= 1'b0;
        end else if (i_cmd.define) begin
            r_defined <= 1'b1;
            r_taken   <= 1'b0;
        end else if (i_cmd.take) begin
            r_taken <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.define) begin
            r_size <= i_cmd.size;
        end
    end

    assign w_fits = r_defined && !r_taken && (r_size >= i_probe.want);

    always_comb begin
        w_pick = 1'b0;
        priority if (!w_fits) begin
            w_pick = 1'b0;
        end else if (!i_probe.found) begin
            w_pick = 1'b1;
        end else if (i_probe.policy == fpfa_pkg::PolicyBest) begin
            w_pick = r_size < i_probe.pick_size;
        end else if (i_probe.policy == fpfa_pkg::PolicyWorst) begin
            w_pick = r_size > i_probe.pick_size;
        end else begin
            w_pick = 1'b0;
        end
    end

    always_comb begin
        n_probe         = i_probe;
        n_probe.cur_idx = i_probe.cur_idx + fpfa_pkg::SlotIdxW'(1);
        if (w_pick) begin
            n_probe.found     = 1'b1;
            n_probe.pick_idx  = i_probe.cur_idx;
            n_probe.pick_size = r_size;
        end
    end

    // Only the active bit needs a reset; the rest of the record is ignored
    // while it is low.
    always_ff @(posedge i_clk) begin
        r_probe.want      <= n_probe.want;
        r_probe.policy    <= n_probe.policy;
        r_probe.found     <= n_probe.found;
        r_probe.pick_idx  <= n_probe.pick_idx;
        r_probe.pick_size <= n_probe.pick_size;
        r_probe.cur_idx   <= n_probe.cur_idx;
        if (!i_rst_n) begin
            r_probe.active <= 1'b0;
        end else begin
            r_probe.active <= n_probe.active;
        end
    end

    assign o_probe = r_probe;

endmodule

[rtl/core/fpfa_checker.sv]
// Port-level checker for the fixed-partition fit allocator and the bind that
// attaches it to fixed_partition_fit_allocator_top. Uses fpfa_pkg.
`timescale 1ns / 1ps

module fpfa_checker (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         start,
    input logic                         busy,
    input logic                         i_req_type,
    input logic                         o_result_strobe,
    input logic                         o_granted,
    input logic [fpfa_pkg::SlotW-1:0]   o_chosen_slot,
    input logic [fpfa_pkg::SeqW-1:0]    o_request_number
);

    // A define item answers in the next cycle with an all-zero result.
    a_define_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_req_type == fpfa_pkg::ReqDefine)
        |=> (o_result_strobe && !o_granted && o_chosen_slot == '0
             && o_request_number == '0))
        else $error("define item did not give a zero result in the next cycle");

    // An allocate item always starts a search.
    a_alloc_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_req_type == fpfa_pkg::ReqAlloc) |=> busy)
        else $error("allocate item did not raise busy");

    // Results appear only once the search is over.
    a_strobe_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_strobe |-> !busy)
        else $error("result strobed while busy");

    // A result without a grant names no partition.
    a_no_grant_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_strobe && !o_granted) |-> (o_chosen_slot == '0))
        else $error("chosen slot nonzero without a grant");

endmodule

bind fixed_partition_fit_allocator_top fpfa_checker u_fpfa_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .start            (start),
    .busy             (busy),
    .i_req_type       (i_req_type),
    .o_result_strobe  (o_result_strobe),
    .o_granted        (o_granted),
    .o_chosen_slot    (o_chosen_slot),
    .o_request_number (o_request_number)
);

[tb/fixed_partition_fit_allocator_top_tb.sv]
// Testbench for the fixed-partition fit allocator top level.
// It runs directed and random items under every fit policy and checks each grant
// against a predictor of the partition table. Depends on fpfa_pkg and the RTL.
`timescale 1ns / 1ps

module fixed_partition_fit_allocator_top_tb;

    localparam int PartCount = 8;
    localparam int CycleLimit = 400000;
    localparam int PhaseItems = 100;
    localparam logic [fpfa_pkg::PolicyW-1:0] PolicyUnused = 2'd3;

    typedef struct {
        logic                        granted;
        logic [fpfa_pkg::SlotW-1:0]  slot;
        logic [fpfa_pkg::SeqW-1:0]   seq;
    } t_grant;

    logic                         i_clk;
    logic                         i_rst_n;
    logic                         start;
    logic                         busy;
    logic                         i_req_type;
    logic [fpfa_pkg::SlotW-1:0]   i_slot_index;
    logic [fpfa_pkg::AmountW-1:0] i_amount;
    logic                         o_result_strobe;
    logic                         o_granted;
    logic [fpfa_pkg::SlotW-1:0]   o_chosen_slot;
    logic [fpfa_pkg::SeqW-1:0]    o_request_number;
    logic                         i_cfg_valid;
    logic                         o_cfg_ready;
    logic [fpfa_pkg::PolicyW-1:0] i_cfg_data;

    // Predictor state: the partition table as the block should hold it.
    logic [fpfa_pkg::AmountW-1:0] part_size [PartCount];
    logic                         part_defined [PartCount];
    logic                         part_taken [PartCount];
    logic [fpfa_pkg::SeqW-1:0]    alloc_seq;
    logic [fpfa_pkg::PolicyW-1:0] fit_policy;

    t_grant pending_grants[$];
    int     error_count;
    int     cycle_count;

    fixed_partition_fit_allocator_top #(
        .SLOT_COUNT(PartCount)
    ) dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .start            (start),
        .busy             (busy),
        .i_req_type       (i_req_type),
        .i_slot_index     (i_slot_index),
        .i_amount         (i_amount),
        .o_result_strobe  (o_result_strobe),
        .o_granted        (o_granted),
        .o_chosen_slot    (o_chosen_slot),
        .o_request_number (o_request_number),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_data       (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Applies one item to the table copy and returns the grant it should cause.
    function automatic t_grant predict_grant(logic kind, logic [fpfa_pkg::SlotW-1:0] idx,
                                             logic [fpfa_pkg::AmountW-1:0] amt);
        t_grant g;
        int     pick;
        g.granted = 1'b0;
        g.slot    = '0;
        g.seq     = '0;
        if (kind == fpfa_pkg::ReqDefine) begin
            part_size[idx]    = amt;
            part_defined[idx] = 1'b1;
            part_taken[idx]   = 1'b0;
        end else begin
            pick = -1;
            for (int j = 0; j < PartCount; j++) begin
                if (!part_defined[j] || part_taken[j] || part_size[j] < amt)
                    continue;
                if (pick < 0) begin
                    pick = j;
                    // First fit, and the unused policy code, stop at the lowest index.
                    if (fit_policy != fpfa_pkg::PolicyBest
                        && fit_policy != fpfa_pkg::PolicyWorst)
                        break;
                end else if (fit_policy == fpfa_pkg::PolicyBest
                             && part_size[j] < part_size[pick]) begin
                    pick = j;
                end else if (fit_policy == fpfa_pkg::PolicyWorst
                             && part_size[j] > part_size[pick]) begin
                    pick = j;
                end
            end
            g.seq = alloc_seq;
            if (pick >= 0) begin
                part_taken[pick] = 1'b1;
                g.granted = 1'b1;
                g.slot = pick[fpfa_pkg::SlotW-1:0];
            end
            alloc_seq = alloc_seq + 1'b1;
        end
        return g;
    endfunction

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CycleLimit) begin
            $display("Some tests failed");
            $finish;
        end
    end

    always @(posedge i_clk) begin : check_grants
        t_grant want;
        if (i_rst_n && o_result_strobe) begin
            if (pending_grants.size() == 0) begin
                $error("result strobe with no item outstanding");
                error_count++;
            end else begin
                want = pending_grants.pop_front();
                if (o_granted !== want.granted) begin
                    $error("granted: expected %0d, actual %0d", want.granted, o_granted);
                    error_count++;
                end
                if (o_chosen_slot !== want.slot) begin
                    $error("chosen_slot: expected %0d, actual %0d", want.slot, o_chosen_slot);
                    error_count++;
                end
                if (o_request_number !== want.seq) begin
                    $error("request_number: expected %0d, actual %0d", want.seq,
                           o_request_number);
                    error_count++;
                end
            end
        end
    end

    // Holds start high until the block takes the item, then records its grant.
    task automatic send_item(logic kind, logic [fpfa_pkg::SlotW-1:0] idx,
                             logic [fpfa_pkg::AmountW-1:0] amt);
        @(negedge i_clk);
        start        <= 1'b1;
        i_req_type   <= kind;
        i_slot_index <= idx;
        i_amount     <= amt;
        do @(posedge i_clk); while (busy);
        pending_grants.push_back(predict_grant(kind, idx, amt));
    endtask

    task automatic idle_cycles(int n);
        repeat (n) begin
            @(negedge i_clk);
            start        <= 1'b0;
            i_req_type   <= 1'($urandom);
            i_slot_index <= fpfa_pkg::SlotW'($urandom);
            i_amount     <= fpfa_pkg::AmountW'($urandom);
        end
    endtask

    task automatic random_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return;
        else if (r < 90)
            idle_cycles($urandom_range(1, 3));
        else
            idle_cycles($urandom_range(10, 40));
    endtask

    task automatic drain_grants();
        @(negedge i_clk);
        start <= 1'b0;
        while (pending_grants.size() != 0) @(posedge i_clk);
        repeat (3) @(posedge i_clk);
    endtask

    task automatic write_policy(logic [fpfa_pkg::PolicyW-1:0] value);
        drain_grants();
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        fit_policy = value;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic test_empty_table();
        send_item(fpfa_pkg::ReqAlloc, 3'd0, 16'd0);
        send_item(fpfa_pkg::ReqAlloc, 3'd7, 16'hFFFF);
    endtask

    task automatic test_directed_policies();
        send_item(fpfa_pkg::ReqDefine, 3'd0, 16'd100);
        send_item(fpfa_pkg::ReqDefine, 3'd1, 16'd50);
        send_item(fpfa_pkg::ReqDefine, 3'd2, 16'd300);
        send_item(fpfa_pkg::ReqDefine, 3'd3, 16'd50);
        send_item(fpfa_pkg::ReqDefine, 3'd4, 16'hFFFF);
        send_item(fpfa_pkg::ReqDefine, 3'd5, 16'd0);
        send_item(fpfa_pkg::ReqDefine, 3'd6, 16'd300);
        send_item(fpfa_pkg::ReqDefine, 3'd7, 16'd200);
        send_item(fpfa_pkg::ReqAlloc, 3'd5, 16'd60);
        write_policy(fpfa_pkg::PolicyBest);
        // Two partitions of 50 tie; the lower index must win.
        send_item(fpfa_pkg::ReqAlloc, 3'd0, 16'd40);
        write_policy(fpfa_pkg::PolicyWorst);
        send_item(fpfa_pkg::ReqAlloc, 3'd0, 16'd0);
        send_item(fpfa_pkg::ReqAlloc, 3'd0, 16'd250);
        send_item(fpfa_pkg::ReqAlloc, 3'd0, 16'hFFFF);
        // Redefining the taken largest partition makes it free again.
        send_item(fpfa_pkg::ReqDefine, 3'd4, 16'hFFFF);
        send_item(fpfa_pkg::ReqAlloc, 3'd2, 16'hFFFF);
        write_policy(PolicyUnused);
        send_item(fpfa_pkg::ReqAlloc, 3'd0, 16'd0);
        send_item(fpfa_pkg::ReqAlloc, 3'd0, 16'd1);
        send_item(fpfa_pkg::ReqAlloc, 3'd0, 16'd0);
    endtask

    task automatic test_random_phase(logic [fpfa_pkg::PolicyW-1:0] policy, bit with_gaps);
        logic                         kind;
        logic [fpfa_pkg::AmountW-1:0] amt;
        int                           r;
        write_policy(policy);
        for (int n = 0; n < PhaseItems; n++) begin
            kind = ($urandom_range(0, 99) < 35) ? fpfa_pkg::ReqDefine : fpfa_pkg::ReqAlloc;
            r = $urandom_range(0, 9);
            if (r == 0)
                amt = '0;
            else if (r == 1)
                amt = '1;
            else if (r < 4)
                amt = fpfa_pkg::AmountW'($urandom);
            else
                // Coarse sizes give ties.
                amt = fpfa_pkg::AmountW'($urandom_range(0, 15) << 12);
            send_item(kind, fpfa_pkg::SlotW'($urandom), amt);
            if (with_gaps)
                random_gap();
            if ($urandom_range(0, 99) == 0)
                drain_grants();
        end
    endtask

    initial begin
        logic [fpfa_pkg::PolicyW-1:0] phase_policy [8];
        phase_policy = '{fpfa_pkg::PolicyFirst, fpfa_pkg::PolicyBest, fpfa_pkg::PolicyWorst,
                         PolicyUnused, fpfa_pkg::PolicyWorst, fpfa_pkg::PolicyBest,
                         fpfa_pkg::PolicyFirst, fpfa_pkg::PolicyFirst};
        phase_policy[7] = fpfa_pkg::PolicyW'($urandom_range(0, 3));
        error_count  = 0;
        cycle_count  = 0;
        start        = 1'b0;
        i_req_type   = 1'b0;
        i_slot_index = '0;
        i_amount     = '0;
        i_cfg_valid  = 1'b0;
        i_cfg_data   = '0;
        i_rst_n      = 1'b0;
        for (int j = 0; j < PartCount; j++) begin
            part_size[j]    = '0;
            part_defined[j] = 1'b0;
            part_taken[j]   = 1'b0;
        end
        alloc_seq  = '0;
        fit_policy = fpfa_pkg::PolicyFirst;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_empty_table();
        test_directed_policies();
        for (int p = 0; p < 8; p++)
            test_random_phase(phase_policy[p], (p % 3) != 2);

        drain_grants();
        repeat (20) @(posedge i_clk);
        if (error_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

[filelist.f]
rtl/core/fpfa_pkg.sv
rtl/core/fpfa_cell.sv
rtl/core/fixed_partition_fit_allocator_top.sv
rtl/core/fpfa_checker.sv
tb/fixed_partition_fit_allocator_top_tb.sv
